/* rtl/rmq_pkg.sv */
// rmq_pkg: shared types and constants of the rotation matrix to quaternion unit
// used by every module of the block, no dependencies
package rmq_pkg;

   localparam int DEFAULT_DATA_WIDTH = 32;
   localparam int DEFAULT_FRAC_BITS  = 30;

   localparam int NORM_W   = 31;
   localparam int NORM_TOP = 30;
   localparam int SQ_W     = 62;
   localparam int SUM_W    = 64;
   localparam int ROOT_W   = 32;
   localparam int ROOT_STEPS = 32;

   localparam int THR_W = 31;
   localparam logic [THR_W-1:0] THR_RESET = 31'd11;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_TRACE_THRESHOLD = 1'b0;

   typedef enum logic [1:0] {
      BR_W = 2'd0,
      BR_X = 2'd1,
      BR_Y = 2'd2,
      BR_Z = 2'd3
   } branch_type;

   typedef struct packed {
      branch_type branch;
      logic       degen;
      logic       zero;
      logic [3:0] neg;
   } meta_type;

endpackage

/* rtl/rmq_intf.sv */
// rmq_req_if and rmq_rsp_if: valid/ready channels of the quaternion unit
// depends on nothing but the data width parameter
interface rmq_req_if #(parameter int DATA_WIDTH = 32);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] m_r0c0;
   logic [DATA_WIDTH-1:0] m_r0c1;
   logic [DATA_WIDTH-1:0] m_r0c2;
   logic [DATA_WIDTH-1:0] m_r1c0;
   logic [DATA_WIDTH-1:0] m_r1c1;
   logic [DATA_WIDTH-1:0] m_r1c2;
   logic [DATA_WIDTH-1:0] m_r2c0;
   logic [DATA_WIDTH-1:0] m_r2c1;
   logic [DATA_WIDTH-1:0] m_r2c2;
   modport source (output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                   m_r2c0, m_r2c1, m_r2c2, input ready);
   modport sink (input valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                 m_r2c0, m_r2c1, m_r2c2, output ready);
endinterface

interface rmq_rsp_if #(parameter int DATA_WIDTH = 32);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] quat_w;
   logic [DATA_WIDTH-1:0] quat_x;
   logic [DATA_WIDTH-1:0] quat_y;
   logic [DATA_WIDTH-1:0] quat_z;
   logic [1:0]            branch_taken;
   logic                  degenerate;
   modport source (output valid, quat_w, quat_x, quat_y, quat_z, branch_taken,
                   degenerate, input ready);
   modport sink (input valid, quat_w, quat_x, quat_y, quat_z, branch_taken,
                 degenerate, output ready);
endinterface

/* rtl/rmq_front.sv */
// rmq_front: clamp, branch select, component build and block normalization
// depends on rmq_pkg
module rmq_front #(
   parameter int DATA_WIDTH = rmq_pkg::DEFAULT_DATA_WIDTH,
   parameter int FRAC_BITS  = rmq_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [rmq_pkg::THR_W-1:0]             thr,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [8:0][DATA_WIDTH-1:0]            in_m,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [3:0][rmq_pkg::NORM_W-1:0]       out_mag,
   output rmq_pkg::meta_type                     out_meta
);
   import rmq_pkg::*;

   localparam int FE  = (FRAC_BITS > 60) ? 60 : FRAC_BITS;
   localparam int PRE = FRAC_BITS - FE;
   localparam int EW  = FE + 2;
   localparam int CW  = FE + 4;
   localparam int MW  = FE + 3;
   localparam int XW  = ((DATA_WIDTH > FRAC_BITS + 2) ? DATA_WIDTH : FRAC_BITS + 2) + 1;
   localparam int PW  = $clog2(MW);
   localparam int NS  = 4;
   localparam logic signed [XW-1:0] ONE_X = {{(XW-1){1'b0}}, 1'b1} << FRAC_BITS;
   localparam logic signed [CW-1:0] UNIT  = {{(CW-1){1'b0}}, 1'b1} << FE;

   logic [NS-1:0] vld_ff;
   logic [NS:0]   rdy;

   logic signed [EW-1:0] e_ff [9];
   logic signed [EW-1:0] e_in [9];
   logic signed [CW-1:0] c_ff [4];
   logic signed [CW-1:0] c_in [4];
   meta_type             m2_ff, m2_in, m3_ff, m3_in, m4_ff, m4_in;
   logic [3:0][MW-1:0]   mag_ff, mag_in;
   logic [MW-1:0]        mx_ff, mx_in;
   logic [3:0][NORM_W-1:0] nmag_ff, nmag_in;

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[k-1];
            end
         end
      end
   end

   // clamp to +-1.0 and drop extra fraction bits
   always_comb begin
      logic signed [XW-1:0] v;
      logic signed [XW-1:0] vs;
      for (int i = 0; i < 9; i++) begin
         v = {{(XW-DATA_WIDTH){in_m[i][DATA_WIDTH-1]}}, in_m[i]};
         if (v > ONE_X) v = ONE_X;
         if (v < -ONE_X) v = -ONE_X;
         vs = v >>> PRE;
         e_in[i] = vs[EW-1:0];
      end
   end

   // branch choice and unnormalized components
   always_comb begin
      logic signed [CW-1:0] d [9];
      logic signed [CW-1:0] t;
      logic signed [CW-1:0] arg;
      logic signed [64:0]   tx;
      logic signed [64:0]   lx;
      for (int i = 0; i < 9; i++) begin
         d[i] = CW'(e_ff[i]);
      end
      t  = d[0] + d[4] + d[8] + UNIT;
      tx = 65'(t);
      lx = 65'(thr >> PRE);
      m2_in = '0;
      arg = '0;
      if (tx > lx) begin
         m2_in.branch = BR_W;
         c_in[0] = t;
         c_in[1] = d[5] - d[7];
         c_in[2] = d[6] - d[2];
         c_in[3] = d[1] - d[3];
      end else begin
         if (d[0] > d[4] && d[0] > d[8]) begin
            m2_in.branch = BR_X;
            arg = (d[0] - (d[4] + d[8])) + UNIT;
         end else if (d[4] > d[8]) begin
            m2_in.branch = BR_Y;
            arg = (d[4] - (d[8] + d[0])) + UNIT;
         end else begin
            m2_in.branch = BR_Z;
            arg = (d[8] - (d[0] + d[4])) + UNIT;
         end
         if (arg <= 0) begin
            arg = '0;
            m2_in.degen = 1'b1;
         end
         case (m2_in.branch)
            BR_X: begin
               c_in[0] = d[5] - d[7]; c_in[1] = arg;
               c_in[2] = d[3] + d[1]; c_in[3] = d[2] + d[6];
            end
            BR_Y: begin
               c_in[0] = d[6] - d[2]; c_in[1] = d[3] + d[1];
               c_in[2] = arg;         c_in[3] = d[7] + d[5];
            end
            default: begin
               c_in[0] = d[1] - d[3]; c_in[1] = d[2] + d[6];
               c_in[2] = d[7] + d[5]; c_in[3] = arg;
            end
         endcase
      end
   end

   // magnitudes, signs and largest magnitude
   always_comb begin
      logic signed [CW-1:0] a;
      logic [MW-1:0] m01, m23;
      m3_in = m2_ff;
      for (int i = 0; i < 4; i++) begin
         m3_in.neg[i] = c_ff[i] < 0;
         a = (c_ff[i] < 0) ? -c_ff[i] : c_ff[i];
         mag_in[i] = a[MW-1:0];
      end
      m01 = (mag_in[0] > mag_in[1]) ? mag_in[0] : mag_in[1];
      m23 = (mag_in[2] > mag_in[3]) ? mag_in[2] : mag_in[3];
      mx_in = (m01 > m23) ? m01 : m23;
   end

   // shift all four so the largest has its top bit at NORM_TOP
   always_comb begin
      logic [PW-1:0] p;
      logic [MW+NORM_TOP-1:0] wide;
      p = '0;
      for (int i = 0; i < MW; i++) begin
         if (mx_ff[i]) p = PW'(i);
      end
      m4_in = m3_ff;
      m4_in.zero = (mx_ff == '0);
      for (int i = 0; i < 4; i++) begin
         wide = {mag_ff[i], {NORM_TOP{1'b0}}} >> p;
         nmag_in[i] = wide[NORM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) e_ff <= e_in;
      if (rdy[1]) begin
         c_ff  <= c_in;
         m2_ff <= m2_in;
      end
      if (rdy[2]) begin
         mag_ff <= mag_in;
         mx_ff  <= mx_in;
         m3_ff  <= m3_in;
      end
      if (rdy[3]) begin
         nmag_ff <= nmag_in;
         m4_ff   <= m4_in;
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_mag   = nmag_ff;
   assign out_meta  = m4_ff;

endmodule

/* rtl/rmq_sqrt.sv */
// rmq_sqrt: sum of squares and pipelined integer square root, one bit a stage
// depends on rmq_pkg
module rmq_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [3:0][rmq_pkg::NORM_W-1:0]   in_mag,
   input  rmq_pkg::meta_type                 in_meta,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [3:0][rmq_pkg::NORM_W-1:0]   out_mag,
   output rmq_pkg::meta_type                 out_meta,
   output logic [rmq_pkg::ROOT_W-1:0]        out_root
);
   import rmq_pkg::*;

   localparam int NS = ROOT_STEPS + 2;

   logic [NS-1:0] vld_ff;
   logic [NS:0]   rdy;

   logic [3:0][NORM_W-1:0] mag_ff [NS];
   meta_type               meta_ff [NS];
   logic [3:0][SQ_W-1:0]   sq_ff, sq_in;
   logic [SUM_W-1:0]       v_ff [ROOT_STEPS+1];
   logic [SUM_W-1:0]       r_ff [ROOT_STEPS+1];
   logic [SUM_W-1:0]       v_in [ROOT_STEPS+1];
   logic [SUM_W-1:0]       r_in [ROOT_STEPS+1];

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sq_in[i] = SQ_W'(in_mag[i]) * SQ_W'(in_mag[i]);
      end
      v_in[0] = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]) + SUM_W'(sq_ff[3]);
      r_in[0] = '0;
      for (int j = 1; j <= ROOT_STEPS; j++) begin
         logic [SUM_W:0] rb;
         rb = {1'b0, r_ff[j-1]} + ((SUM_W+1)'(1) << (2 * (ROOT_STEPS - j)));
         if ({1'b0, v_ff[j-1]} >= rb) begin
            v_in[j] = v_ff[j-1] - rb[SUM_W-1:0];
            r_in[j] = (r_ff[j-1] >> 1) + (SUM_W'(1) << (2 * (ROOT_STEPS - j)));
         end else begin
            v_in[j] = v_ff[j-1];
            r_in[j] = r_ff[j-1] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (rdy[k]) begin
            mag_ff[k]  <= (k == 0) ? in_mag : mag_ff[k-1];
            meta_ff[k] <= (k == 0) ? in_meta : meta_ff[k-1];
         end
      end
      if (rdy[0]) sq_ff <= sq_in;
      for (int j = 0; j <= ROOT_STEPS; j++) begin
         if (rdy[j+1]) begin
            v_ff[j] <= v_in[j];
            r_ff[j] <= r_in[j];
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_mag   = mag_ff[NS-1];
   assign out_meta  = meta_ff[NS-1];
   assign out_root  = r_ff[ROOT_STEPS][ROOT_W-1:0];

endmodule

/* rtl/rmq_div.sv */
// rmq_div: four pipelined restoring dividers, rounding, sign and identity output
// depends on rmq_pkg
module rmq_div #(
   parameter int DATA_WIDTH = rmq_pkg::DEFAULT_DATA_WIDTH,
   parameter int FRAC_BITS  = rmq_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [3:0][rmq_pkg::NORM_W-1:0]   in_mag,
   input  rmq_pkg::meta_type                 in_meta,
   input  logic [rmq_pkg::ROOT_W-1:0]        in_root,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [3:0][DATA_WIDTH-1:0]        out_quat,
   output logic [1:0]                        out_branch,
   output logic                              out_degen
);
   import rmq_pkg::*;

   localparam int NSTEP = FRAC_BITS + 1;
   localparam int NS    = NSTEP + 2;
   localparam int QW    = FRAC_BITS + 2;
   localparam int RW    = ROOT_W + 1;
   localparam int OW    = (DATA_WIDTH > FRAC_BITS + 2) ? DATA_WIDTH : FRAC_BITS + 2;
   localparam logic [QW:0] ONE_Q = {{QW{1'b0}}, 1'b1} << FRAC_BITS;
   localparam logic [OW-1:0] ONE_O = {{(OW-1){1'b0}}, 1'b1} << FRAC_BITS;

   logic [NS-1:0] vld_ff;
   logic [NS:0]   rdy;

   logic [3:0][QW-1:0]  q_ff [NSTEP+1];
   logic [3:0][QW-1:0]  q_in [NSTEP+1];
   logic [3:0][RW-1:0]  rem_ff [NSTEP+1];
   logic [3:0][RW-1:0]  rem_in [NSTEP+1];
   logic [ROOT_W-1:0]   root_ff [NSTEP+1];
   meta_type            meta_ff [NSTEP+1];
   logic [3:0][DATA_WIDTH-1:0] quat_ff, quat_in;
   logic [1:0]          branch_ff;
   logic                degen_ff;

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      logic [RW-1:0] m;
      logic [RW-1:0] r2;
      logic [RW-1:0] lx;
      logic [QW:0]   qr;
      logic [OW-1:0] res;
      // integer part, the magnitude never exceeds the length
      for (int i = 0; i < 4; i++) begin
         m  = RW'(in_mag[i]);
         lx = RW'(in_root);
         if (m >= lx) begin
            rem_in[0][i] = m - lx;
            q_in[0][i]   = QW'(1);
         end else begin
            rem_in[0][i] = m;
            q_in[0][i]   = '0;
         end
      end
      for (int j = 1; j <= NSTEP; j++) begin
         lx = RW'(root_ff[j-1]);
         for (int i = 0; i < 4; i++) begin
            r2 = {rem_ff[j-1][i][RW-2:0], 1'b0};
            if (r2 >= lx) begin
               rem_in[j][i] = r2 - lx;
               q_in[j][i]   = {q_ff[j-1][i][QW-2:0], 1'b1};
            end else begin
               rem_in[j][i] = r2;
               q_in[j][i]   = {q_ff[j-1][i][QW-2:0], 1'b0};
            end
         end
      end
      for (int i = 0; i < 4; i++) begin
         qr = ((QW+1)'(q_ff[NSTEP][i]) + (QW+1)'(1)) >> 1;
         if (qr > ONE_Q) qr = ONE_Q;
         res = OW'(qr);
         if (meta_ff[NSTEP].neg[i]) res = -res;
         quat_in[i] = res[DATA_WIDTH-1:0];
      end
      if (meta_ff[NSTEP].zero) begin
         quat_in[0] = ONE_O[DATA_WIDTH-1:0];
         quat_in[1] = '0;
         quat_in[2] = '0;
         quat_in[3] = '0;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j <= NSTEP; j++) begin
         if (rdy[j]) begin
            q_ff[j]    <= q_in[j];
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= (j == 0) ? in_root : root_ff[j-1];
            meta_ff[j] <= (j == 0) ? in_meta : meta_ff[j-1];
         end
      end
      if (rdy[NS-1]) begin
         quat_ff   <= quat_in;
         branch_ff <= meta_ff[NSTEP].branch;
         degen_ff  <= meta_ff[NSTEP].degen | meta_ff[NSTEP].zero;
      end
   end

   assign out_valid  = vld_ff[NS-1];
   assign out_quat   = quat_ff;
   assign out_branch = branch_ff;
   assign out_degen  = degen_ff;

endmodule

/* rtl/rotation_matrix_to_quaternion_unit.sv */
// rotation matrix to unit quaternion, Q2.30 in and out
// pipeline of 4 front stages, 34 for squares, sum and the one-bit-a-stage square root,
// and FRAC_BITS + 3 for the divider
// throughput one transaction per cycle while rsp.ready is high; every stage holds under backpressure
// synchronous reset empties the pipeline and sets trace_threshold to 11
module rotation_matrix_to_quaternion_unit #(
   parameter int DATA_WIDTH = rmq_pkg::DEFAULT_DATA_WIDTH,
   parameter int FRAC_BITS  = rmq_pkg::DEFAULT_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   rmq_req_if.sink                            req,
   rmq_rsp_if.source                          rsp,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rmq_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [rmq_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [rmq_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import rmq_pkg::*;

   logic [THR_W-1:0] thr_ff, thr_in;

   logic [8:0][DATA_WIDTH-1:0]   in_m;
   logic                         f_valid, f_ready, s_valid, s_ready;
   logic [3:0][NORM_W-1:0]       f_mag, s_mag;
   meta_type                     f_meta, s_meta;
   logic [ROOT_W-1:0]            s_root;
   logic [3:0][DATA_WIDTH-1:0]   quat;

   assign pready = 1'b1;

   always_comb begin
      thr_in = thr_ff;
      if (psel && penable && pwrite && paddr[CSR_ADDR_W-1] == REG_TRACE_THRESHOLD) begin
         thr_in = pwdata[THR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign prdata = (paddr[CSR_ADDR_W-1] == REG_TRACE_THRESHOLD) ?
                   CSR_DATA_W'(thr_ff) : '0;

   assign in_m = {req.m_r2c2, req.m_r2c1, req.m_r2c0,
                  req.m_r1c2, req.m_r1c1, req.m_r1c0,
                  req.m_r0c2, req.m_r0c1, req.m_r0c0};

   rmq_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .thr       (thr_ff),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_m      (in_m),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_mag   (f_mag),
      .out_meta  (f_meta)
   );

   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_mag    (f_mag),
      .in_meta   (f_meta),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .out_mag   (s_mag),
      .out_meta  (s_meta),
      .out_root  (s_root)
   );

   rmq_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s_valid),
      .in_ready   (s_ready),
      .in_mag     (s_mag),
      .in_meta    (s_meta),
      .in_root    (s_root),
      .out_valid  (rsp.valid),
      .out_ready  (rsp.ready),
      .out_quat   (quat),
      .out_branch (rsp.branch_taken),
      .out_degen  (rsp.degenerate)
   );

   assign rsp.quat_w = quat[0];
   assign rsp.quat_x = quat[1];
   assign rsp.quat_y = quat[2];
   assign rsp.quat_z = quat[3];

endmodule
